>>> hw/rtl/fbm_pkg.sv
// shared constants, widths and state type for the fft bin magnitude block
package fbm_pkg;

  localparam int FFT_POINTS_DEF = 256;

  localparam int WORD_W     = 32;
  localparam int PART_W     = 16;
  localparam int SUM_W      = 32;
  localparam int RAD_W      = 34;
  localparam int MAG_W      = 17;
  localparam int REM_W      = 19;
  localparam int SQRT_STEPS = 17;
  localparam int STEP_W     = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUMSQ,
    ST_SQRT,
    ST_HOLD
  } fbm_state_t;

  // handshake between the sequencer and a multi-cycle unit
  typedef struct packed {
    logic start;
  } fbm_go_t;

  typedef struct packed {
    logic done;
  } fbm_fin_t;

endpackage

>>> hw/rtl/fbm_sumsq.sv
// sum of squares of the two bin parts through one shared multiplier
module fbm_sumsq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbm_pkg::fbm_go_t           go,
  input  logic [fbm_pkg::WORD_W-1:0] bin_word,
  output fbm_pkg::fbm_fin_t          fin,
  output logic [fbm_pkg::SUM_W-1:0]  sum
);
  import fbm_pkg::*;

  logic [PART_W-1:0] re_r, re_nxt;
  logic [PART_W-1:0] im_r, im_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic              busy_r, busy_nxt;
  logic              phase_r, phase_nxt;
  logic              done_r, done_nxt;
  logic [PART_W-1:0] op;
  logic [SUM_W-1:0]  prod;

  // magnitude of a 16-bit two's complement value; the most negative maps to 0x8000
  function automatic logic [PART_W-1:0] abs_part(input logic [PART_W-1:0] v);
    abs_part = v[PART_W-1] ? (~v + PART_W'(1)) : v;
  endfunction

  assign op   = phase_r ? im_r : re_r;
  assign prod = SUM_W'(op) * SUM_W'(op);

  always_comb begin
    re_nxt    = re_r;
    im_nxt    = im_r;
    acc_nxt   = acc_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    if (go.start) begin
      re_nxt    = abs_part(bin_word[PART_W-1:0]);
      im_nxt    = abs_part(bin_word[WORD_W-1:PART_W]);
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (busy_r) begin
      if (!phase_r) begin
        acc_nxt   = prod;
        phase_nxt = 1'b1;
      end else begin
        acc_nxt  = acc_r + prod;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    acc_r <= acc_nxt;
  end

  assign fin.done = done_r;
  assign sum      = acc_r;

endmodule

>>> hw/rtl/fbm_isqrt.sv
// bit-serial floor square root, one result bit per cycle
module fbm_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fbm_pkg::fbm_go_t          go,
  input  logic [fbm_pkg::RAD_W-1:0] radicand,
  output fbm_pkg::fbm_fin_t         fin,
  output logic [fbm_pkg::MAG_W-1:0] root
);
  import fbm_pkg::*;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (go.start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = STEP_W'(SQRT_STEPS);
    end else if (step_r != '0) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_nxt = {root_r[MAG_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      done_nxt = (step_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign fin.done = done_r;
  assign root     = root_r;

endmodule

>>> hw/rtl/fft_bin_magnitude.sv
// top level: magnitude of one fft bin per request, with bin counter and sequencer
//
//   channel  direction  payload                 handshake
//   in_      input      in_bin_word [31:0]      in_valid / in_stall
//   out_     output     out_magnitude [16:0]    out_valid / out_stall
//
// each request runs from acceptance to the next acceptance through the shared 16x16
// multiplier for re^2 + im^2, 17 steps of the bit-serial square root, and the unit
// hand-offs and the output load
// reset (rst_n low, synchronous) clears the sequencer, the bin counter and out_valid
// a stalled result waits in the output register; a new request is still taken then,
// and the finished root waits in the root unit until the output register frees up
module fft_bin_magnitude #(
  parameter int FFT_POINTS = fbm_pkg::FFT_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fbm_pkg::WORD_W-1:0] in_bin_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fbm_pkg::MAG_W-1:0]  out_magnitude
);
  import fbm_pkg::*;

  // half-spectrum length; a degenerate size treats every bin as dc
  localparam int HALF  = (FFT_POINTS / 2 == 0) ? 1 : FFT_POINTS / 2;
  localparam int CNT_W = (HALF > 1) ? $clog2(HALF) : 1;

  fbm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] bin_cnt_r, bin_cnt_nxt;
  logic             dc_r, dc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;

  logic             accept;
  logic             out_free;
  logic             load;

  fbm_go_t          sq_go, rt_go;
  fbm_fin_t         sq_fin, rt_fin;
  logic [SUM_W-1:0] sum;
  logic [RAD_W-1:0] radicand;
  logic [MAG_W-1:0] root;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // dc bin takes sqrt(s), the others sqrt(4s) = 2*sqrt(s)
  assign radicand = dc_r ? {2'b00, sum} : {sum, 2'b00};

  fbm_sumsq u_sumsq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go),
    .bin_word (in_bin_word),
    .fin      (sq_fin),
    .sum      (sum)
  );

  fbm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (rt_go),
    .radicand (radicand),
    .fin      (rt_fin),
    .root     (root)
  );

  // sequencer: next state and unit kicks
  always_comb begin
    state_nxt   = state_r;
    bin_cnt_nxt = bin_cnt_r;
    dc_nxt      = dc_r;
    sq_go.start = 1'b0;
    rt_go.start = 1'b0;
    load        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sq_go.start = 1'b1;
          dc_nxt      = (bin_cnt_r == '0);
          // wrap after the last bin of the half spectrum
          if (bin_cnt_r == CNT_W'(HALF - 1)) begin
            bin_cnt_nxt = '0;
          end else begin
            bin_cnt_nxt = bin_cnt_r + CNT_W'(1);
          end
          state_nxt = ST_SUMSQ;
        end
      end
      ST_SUMSQ: begin
        if (sq_fin.done) begin
          rt_go.start = 1'b1;
          state_nxt   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (rt_fin.done) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // root stays put in the unit until the output register takes it
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    mag_nxt       = mag_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      mag_nxt       = root;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bin_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_cnt_r   <= bin_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dc_r  <= dc_nxt;
    mag_r <= mag_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = mag_r;

endmodule
